### design/lkm_pkg.sv
package lkm_pkg;

	localparam int unsigned KEY_LENGTH_DEF = 10;
	localparam int unsigned KEY_SLOTS      = 16;
	localparam int unsigned CODE_COUNT     = 13;
	localparam int unsigned IDX_W          = 4;
	localparam int unsigned CNT_W          = 4;

	localparam logic [7:0] CHAR_END   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	// key bytes, unused slots hold zero so no nonzero byte matches there
	localparam logic [7:0] KEY_BYTES [KEY_SLOTS] = '{
		8'h70, 8'h74, 8'h6F, 8'h73, 8'h2E, 8'h6C, 8'h61, 8'h6E,
		8'h67, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// two-letter codes: us de fr cz gr es fi sg ru it uk no se
	localparam logic [15:0] CODE_TABLE [CODE_COUNT] = '{
		16'h7573, 16'h6465, 16'h6672, 16'h637A, 16'h6772, 16'h6573, 16'h6669,
		16'h7367, 16'h7275, 16'h6974, 16'h756B, 16'h6E6F, 16'h7365
	};

	typedef enum logic [2:0] {
		PH_KEY,
		PH_FIRST,
		PH_SECOND,
		PH_TERM,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} scan_result_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			r = c + CASE_GAP;
		end
		return r;
	endfunction

	// lowest table position wins
	function automatic scan_result_t code_lookup(input logic [7:0] first,
			input logic [7:0] second);
		scan_result_t r;
		r.found = 1'b0;
		r.index = '0;
		for (int i = CODE_COUNT - 1; i >= 0; i--) begin
			if (CODE_TABLE[i] == {first, second}) begin
				r.found = 1'b1;
				r.index = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### design/lkm_scan.sv
module lkm_scan #(
	parameter int unsigned KEY_LENGTH = lkm_pkg::KEY_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           char_in,
	output lkm_pkg::scan_result_t result
);
	import lkm_pkg::*;

	phase_t           phase_q, phase_d;
	logic             pws_q, pws_d;
	logic             matching_q, matching_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       first_q, first_d;
	scan_result_t     held_q, held_d;

	logic             is_end, is_space, key_hit, start_hit;
	logic [CNT_W:0]   cnt_inc;
	logic [7:0]       folded;
	scan_result_t     lookup;

	assign is_end    = (char_in == CHAR_END);
	assign is_space  = (char_in == CHAR_SPACE);
	assign key_hit   = matching_q && (char_in == KEY_BYTES[cnt_q]);
	assign start_hit = pws_q && (char_in == KEY_BYTES[0]);
	assign cnt_inc   = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign folded    = fold_case(char_in);
	assign lookup    = code_lookup(first_q, folded);

	// result as seen at an end byte
	always_comb begin
		result.found = held_q.found && (phase_q == PH_TERM || phase_q == PH_DONE);
		result.index = result.found ? held_q.index : '0;
	end

	// phase sequencing
	always_comb begin
		phase_d = phase_q;
		if (is_end) begin
			phase_d = PH_KEY;
		end else begin
			unique case (phase_q)
				PH_KEY: begin
					if (key_hit) begin
						if (cnt_inc >= (CNT_W+1)'(KEY_LENGTH)) phase_d = PH_FIRST;
					end else if (!is_space && start_hit) begin
						if (KEY_LENGTH <= 1) phase_d = PH_FIRST;
					end
				end
				PH_FIRST:  phase_d = PH_SECOND;
				PH_SECOND: phase_d = PH_TERM;
				PH_TERM:   phase_d = PH_DONE;
				PH_DONE:   phase_d = PH_DONE;
				default:   phase_d = PH_KEY;
			endcase
		end
	end

	// datapath updates
	always_comb begin
		pws_d      = pws_q;
		matching_d = matching_q;
		cnt_d      = cnt_q;
		first_d    = first_q;
		held_d     = held_q;
		if (is_end) begin
			pws_d      = 1'b1;
			matching_d = 1'b0;
			cnt_d      = '0;
			first_d    = '0;
			held_d     = '0;
		end else begin
			unique case (phase_q)
				PH_KEY: begin
					if (key_hit) begin
						cnt_d = cnt_inc[CNT_W-1:0];
						if (cnt_inc >= (CNT_W+1)'(KEY_LENGTH)) matching_d = 1'b0;
					end else begin
						matching_d = 1'b0;
						if (is_space) begin
							pws_d = 1'b1;
						end else begin
							if (start_hit) begin
								matching_d = (KEY_LENGTH > 1);
								cnt_d      = CNT_W'(1);
							end
							pws_d = 1'b0;
						end
					end
				end
				PH_FIRST:  first_d = folded;
				PH_SECOND: held_d  = lookup;
				PH_TERM: begin
					if (!is_space) held_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_KEY;
			pws_q      <= 1'b1;
			matching_q <= 1'b0;
			cnt_q      <= '0;
			first_q    <= '0;
			held_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			pws_q      <= pws_d;
			matching_q <= matching_d;
			cnt_q      <= cnt_d;
			first_q    <= first_d;
			held_q     <= held_d;
		end
	end

endmodule

### design/cmdline_language_key_matcher_top.sv
// channel | handshake            | payload
// --------+----------------------+---------------------------
// in      | in_valid / in_ready  | char_byte
// out     | out_valid / out_ready| found, country_index
//
// one item per cycle sustained unless an end byte waits on a stalled output;
// an item waits in the input register and the scan state updates as it leaves it
// only the zero end byte makes a result; it loads the output register and
// returns the scan state to its line-start values
// asynchronous active-low reset clears the input stage, scan state and output valid
// a stalled output holds only end bytes; bytes behind a held end byte wait too
module cmdline_language_key_matcher_top #(
	parameter int unsigned KEY_LENGTH = lkm_pkg::KEY_LENGTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                char_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [lkm_pkg::IDX_W-1:0] country_index
);
	import lkm_pkg::*;

	// input register
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         end_s1;
	logic         advance;

	// result register
	logic             out_valid_q;
	logic             found_q;
	logic [IDX_W-1:0] index_q;

	scan_result_t     scan_res;

	assign end_s1 = (char_s1 == CHAR_END);

	// an end byte needs a free (or freeing) result slot, other bytes never wait in the input register
	assign advance  = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
		end
	end

	// per-byte token and key tracking
	lkm_scan #(
		.KEY_LENGTH(KEY_LENGTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_in (char_s1),
		.result  (scan_res)
	);

	// result register, loaded by an end byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			found_q <= scan_res.found;
			index_q <= scan_res.index;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign country_index = index_q;

`ifndef SYNTH
	// a result only appears after an end byte left the input register
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && end_s1))
		else $error("result without end item");

	// a held input item stays put until it advances
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1))
		else $error("input stage lost an item");

	// not found always reports index zero
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> index_q == '0)
		else $error("index set without found");

	// index stays inside the code table
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> index_q <= IDX_W'(CODE_COUNT - 1))
		else $error("index beyond code table");
`endif

endmodule

### sim/tb_cmdline_language_key_matcher_top.sv
module tb_cmdline_language_key_matcher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lkm_pkg::*;

	// search key and code table, kept here as plain bytes
	localparam int unsigned KEY_LEN    = 10;
	localparam int unsigned CODE_NUM   = 13;
	localparam int unsigned STIM_ITEMS = 900;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned TAIL_WAIT  = 8;

	localparam logic [7:0] LANG_KEY [KEY_LEN] = '{
		8'h70, 8'h74, 8'h6F, 8'h73, 8'h2E, 8'h6C, 8'h61, 8'h6E, 8'h67, 8'h3D
	};

	localparam logic [15:0] LANG_CODES [CODE_NUM] = '{
		"us", "de", "fr", "cz", "gr", "es", "fi", "sg", "ru", "it", "uk", "no", "se"
	};

	// kinds of token the random line builder strings together
	typedef enum int {
		TOK_GOOD_CODE,
		TOK_ODD_VALUE,
		TOK_SHORT_VALUE,
		TOK_CUT_KEY,
		TOK_CASE_KEY,
		TOK_WORD,
		TOK_NOISE
	} token_kind_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} country_verdict_t;

	// line scanner prediction plus the queue of verdicts still owed by the block
	class lang_key_scoreboard;
		logic             prev_space;
		logic [3:0]       key_pos;
		logic             key_live;
		logic [1:0]       value_seen;
		logic [7:0]       first_letter;
		logic             key_done;
		logic             code_hit;
		logic [IDX_W-1:0] code_pos;
		country_verdict_t verdict_q[$];
		int unsigned      mismatches;

		function new();
			mismatches = 0;
			start_line();
		endfunction

		function void start_line();
			prev_space   = 1'b1;
			key_pos      = '0;
			key_live     = 1'b0;
			value_seen   = '0;
			first_letter = '0;
			key_done     = 1'b0;
			code_hit     = 1'b0;
			code_pos     = '0;
		endfunction

		function logic [7:0] lower(input logic [7:0] c);
			if (c >= "A" && c <= "Z") begin
				return c + 8'h20;
			end
			return c;
		endfunction

		function void check_key_complete();
			if (key_pos >= KEY_LEN) begin
				key_live   = 1'b0;
				key_done   = 1'b1;
				value_seen = '0;
			end
		endfunction

		function void note_byte(input logic [7:0] c);
			country_verdict_t v;
			logic [7:0]       second;
			if (c == CHAR_END) begin
				v.found = key_done && value_seen >= 2 && code_hit;
				v.index = v.found ? code_pos : '0;
				verdict_q.push_back(v);
				start_line();
				return;
			end
			if (key_done) begin
				case (value_seen)
					2'd0: begin
						first_letter = lower(c);
						value_seen   = 2'd1;
					end
					2'd1: begin
						second   = lower(c);
						code_hit = 1'b0;
						code_pos = '0;
						for (int i = 0; i < CODE_NUM; i++) begin
							if (!code_hit && LANG_CODES[i] == {first_letter, second}) begin
								code_hit = 1'b1;
								code_pos = IDX_W'(i);
							end
						end
						value_seen = 2'd2;
					end
					2'd2: begin
						if (c != CHAR_SPACE) begin
							code_hit = 1'b0;
							code_pos = '0;
						end
						value_seen = 2'd3;
					end
					default: begin
					end
				endcase
				return;
			end
			if (key_live && c == LANG_KEY[key_pos]) begin
				key_pos = key_pos + 4'd1;
				check_key_complete();
				return;
			end
			key_live = 1'b0;
			if (c == CHAR_SPACE) begin
				prev_space = 1'b1;
			end else begin
				if (prev_space && c == LANG_KEY[0]) begin
					key_live = 1'b1;
					key_pos  = 4'd1;
					check_key_complete();
				end
				prev_space = 1'b0;
			end
		endfunction

		function void check_verdict(input logic f, input logic [IDX_W-1:0] idx);
			country_verdict_t v;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: found=%0d country_index=%0d", f, idx);
				end
				return;
			end
			v = verdict_q.pop_front();
			if (f !== v.found || idx !== v.index) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected found=%0d country_index=%0d, got found=%0d country_index=%0d",
						v.found, v.index, f, idx);
				end
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       char_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             found;
	logic [IDX_W-1:0] country_index;

	lang_key_scoreboard sb = new();

	// sender and receiver burst counters, hold-off request for the receiver
	int unsigned tx_burst = 0;
	int unsigned rx_burst = 0;
	int unsigned hold_req = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	cmdline_language_key_matcher_top #(
		.KEY_LENGTH(KEY_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.country_index(country_index)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// one character per call, entered and left at a falling edge
	task automatic send_char(input logic [7:0] b);
		int unsigned gap;
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else begin
			gap = $urandom_range(0, 16);
			// now and then a stretch with no gaps at all
			if ($urandom_range(0, 39) == 0) begin
				tx_burst = $urandom_range(30, 80);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	task automatic send_key();
		foreach (LANG_KEY[i]) begin
			send_char(LANG_KEY[i]);
		end
	endtask

	// random lines: some well-formed key values, the rest broken keys, bad values, words and noise
	task automatic send_random_line();
		logic [7:0]  line_q[$];
		token_kind_t kind;
		int unsigned ntok;
		int unsigned r;
		int unsigned cut;
		logic [15:0] code;
		ntok = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) line_q.push_back(CHAR_SPACE);
		end
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(0, 9);
			if (r < 3) kind = TOK_GOOD_CODE;
			else if (r == 3) kind = TOK_ODD_VALUE;
			else if (r == 4) kind = TOK_SHORT_VALUE;
			else if (r == 5) kind = TOK_CUT_KEY;
			else if (r == 6) kind = TOK_CASE_KEY;
			else if (r < 9) kind = TOK_WORD;
			else kind = TOK_NOISE;
			case (kind)
				TOK_GOOD_CODE: begin
					foreach (LANG_KEY[i]) line_q.push_back(LANG_KEY[i]);
					code = LANG_CODES[$urandom_range(0, CODE_NUM - 1)];
					// random upper case on either letter
					line_q.push_back(code[15:8] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
					line_q.push_back(code[7:0] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
					// sometimes a third letter spoils the value
					if ($urandom_range(0, 4) == 0) begin
						line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
					end
				end
				TOK_ODD_VALUE: begin
					foreach (LANG_KEY[i]) line_q.push_back(LANG_KEY[i]);
					repeat (2) line_q.push_back(8'($urandom_range(1, 255)));
				end
				TOK_SHORT_VALUE: begin
					foreach (LANG_KEY[i]) line_q.push_back(LANG_KEY[i]);
					if ($urandom_range(0, 1)) begin
						line_q.push_back(8'($urandom_range("a", "z")));
					end
				end
				TOK_CUT_KEY: begin
					// key prefix, then a random byte or a space
					cut = $urandom_range(1, KEY_LEN - 1);
					for (int i = 0; i < cut; i++) line_q.push_back(LANG_KEY[i]);
					line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE :
						8'($urandom_range(1, 255)));
				end
				TOK_CASE_KEY: begin
					// one key letter in the wrong case unless the chosen byte is no letter, the match is case sensitive
					cut = $urandom_range(0, 8);
					foreach (LANG_KEY[i]) begin
						if (i == cut && LANG_KEY[i] >= "a" && LANG_KEY[i] <= "z") begin
							line_q.push_back(LANG_KEY[i] ^ 8'h20);
						end else begin
							line_q.push_back(LANG_KEY[i]);
						end
					end
					line_q.push_back("d");
					line_q.push_back("e");
				end
				TOK_WORD: begin
					repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range("a", "z")));
				end
				default: begin
					repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(1, 255)));
				end
			endcase
			// separator, occasionally missing so tokens run together
			if (t + 1 < ntok && $urandom_range(0, 7) != 0) begin
				repeat ($urandom_range(1, 3)) line_q.push_back(CHAR_SPACE);
			end
		end
		if ($urandom_range(0, 5) == 0) begin
			line_q.push_back(CHAR_SPACE);
		end
		line_q.push_back(CHAR_END);
		foreach (line_q[i]) begin
			send_char(line_q[i]);
		end
	endtask

	// receiver: random ready gaps, bursts, and one long hold-off on request
	initial begin
		int unsigned wait_cycles;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req > 0) begin
				wait_cycles = hold_req;
				hold_req    = 0;
			end else if (rx_burst > 0) begin
				wait_cycles = 0;
				rx_burst--;
			end else begin
				wait_cycles = $urandom_range(0, 16);
				if ($urandom_range(0, 39) == 0) begin
					rx_burst = $urandom_range(20, 60);
				end
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// result check at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_verdict(found, country_index);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("cmdline_language_key_matcher_top regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		bit pressed;
		bit paused;
		pressed = 1'b0;
		paused  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty line
		send_char(CHAR_END);
		// top byte value, no key
		send_char(8'hFF);
		send_char(CHAR_END);
		// line ends right after the key
		send_key();
		send_char(CHAR_END);
		// key cut by a space, found in the next token, upper case folded, tail ignored
		send_text("pt ");
		send_key();
		send_text("Us junk");
		send_char(CHAR_END);
		// line ends inside the value
		send_key();
		send_text("s");
		send_char(CHAR_END);
		// first key decides even though its value is bad
		send_key();
		send_text("sex ");
		send_key();
		send_text("de");
		send_char(CHAR_END);
		// last table entry after a leading space
		send_text(" ");
		send_key();
		send_text("SE");
		send_char(CHAR_END);

		while (items_sent < STIM_ITEMS) begin
			if (!pressed && items_sent >= STIM_ITEMS / 3) begin
				// receiver stalls while end bytes pile up behind it
				pressed  = 1'b1;
				hold_req = HOLD_LEN;
				tx_burst = 200;
				repeat (40) begin
					if ($urandom_range(0, 1)) begin
						send_char(CHAR_END);
					end else begin
						send_random_line();
					end
				end
			end
			if (!paused && items_sent >= 2 * STIM_ITEMS / 3) begin
				// sender pauses until the block has delivered everything
				paused = 1'b1;
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
				@(negedge clk);
			end
			send_random_line();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("cmdline_language_key_matcher_top regression: pass");
		end else begin
			$display("cmdline_language_key_matcher_top regression: fail");
		end
		$finish;
	end

endmodule
